FILE: hw/rtl/tpa_pkg.sv
package tpa_pkg;

	localparam int VERTEX_BITS      = 16;
	localparam int INDEX_BITS_DEF   = 16;
	localparam int CFG_INDEX_BITS   = 1;
	localparam int CFG_DATA_BITS    = 2;
	localparam int TDATA_IN_BITS    = 16;
	localparam int TDATA_OUT_BITS   = 3 * VERTEX_BITS;

	typedef enum logic [1:0] {
		MODE_NONE  = 2'd0,
		MODE_LIST  = 2'd1,
		MODE_STRIP = 2'd2
	} prim_mode_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_PRIM_MODE = 1'b0,
		REG_START_ODD = 1'b1
	} cfg_reg_t;

	// packed MSB first: first_vertex ends up in the lowest bits
	typedef struct packed {
		logic [VERTEX_BITS-1:0] third_vertex;
		logic [VERTEX_BITS-1:0] second_vertex;
		logic [VERTEX_BITS-1:0] first_vertex;
	} tri_t;

	typedef struct packed {
		logic out_vld;
		logic skid_vld;
	} obuf_stat_t;

endpackage

FILE: hw/rtl/triangle_primitive_assembler.sv
// Triangle assembler: takes one vertex index per beat on s_* (s_tlast marks the last
// index of a list or strip) and returns triangles on m_*. List mode groups three
// indices and emits them reversed; strip mode slides a three-index window, drops
// windows with a repeated index and alternates winding (flipped by start_odd).
// Sustained rate is one index per cycle: the window logic sits between the index
// registers and a result register backed by a one-entry skid buffer, so s_tready
// drops only when both are full. A triangle is registered in the result register or
// in the skid entry. Configuration (cfg_index 0 prim_mode, 1 start_odd) is taken at
// once, cfg_ready is always high; write it only while the block idles.
module triangle_primitive_assembler import tpa_pkg::*; #(
	parameter int INDEX_BITS = INDEX_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [TDATA_IN_BITS-1:0]  s_tdata,   // [15:0] vertex_index
	input  logic                      s_tlast,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [TDATA_OUT_BITS-1:0] m_tdata,   // [15:0] first, [31:16] second, [47:32] third
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	prim_mode_t prim_mode_q;
	logic       start_odd_q;
	logic       accept;
	logic       push;
	tri_t       tri_c, m_data;
	obuf_stat_t obuf_stat;

	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid & s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prim_mode_q <= MODE_LIST;
			start_odd_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PRIM_MODE: prim_mode_q <= prim_mode_t'(cfg_data);
				REG_START_ODD: start_odd_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	tpa_core #(
		.INDEX_BITS(INDEX_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (accept),
		.vertex_index(s_tdata[VERTEX_BITS-1:0]),
		.last        (s_tlast),
		.prim_mode   (prim_mode_q),
		.start_odd   (start_odd_q),
		.push        (push),
		.tri_out     (tri_c)
	);

	tpa_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(tri_c),
		.in_ready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_data   (m_data),
		.stat     (obuf_stat)
	);

	assign m_tdata = m_data;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		obuf_stat.skid_vld |-> obuf_stat.out_vld)
		else $error("skid entry held with empty output register");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(obuf_stat.out_vld && !m_tready && push) |=> obuf_stat.skid_vld)
		else $error("stalled triangle beat not kept in skid entry");

	a_emit_mode: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (prim_mode_q == MODE_LIST || prim_mode_q == MODE_STRIP))
		else $error("triangle emitted in a mode without output");

	a_strip_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		(push && prim_mode_q == MODE_STRIP) |->
		(tri_c.first_vertex != tri_c.second_vertex &&
		 tri_c.second_vertex != tri_c.third_vertex))
		else $error("degenerate strip triangle emitted");

endmodule

FILE: hw/rtl/tpa_core.sv
module tpa_core import tpa_pkg::*; #(
	parameter int INDEX_BITS = INDEX_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic [VERTEX_BITS-1:0] vertex_index,
	input  logic                   last,
	input  prim_mode_t             prim_mode,
	input  logic                   start_odd,
	output logic                   push,
	output tri_t                   tri_out
);

	logic [INDEX_BITS-1:0] older_q, newer_q, older_d, newer_d;
	logic [INDEX_BITS-1:0] v;
	logic [1:0]            fill_q, fill_d;
	logic                  parity_q, parity_d;
	logic                  emit;
	logic                  distinct;

	assign v        = INDEX_BITS'(vertex_index);
	assign distinct = (older_q != newer_q) && (older_q != v) && (newer_q != v);

	always_comb begin
		fill_d   = fill_q;
		parity_d = parity_q;
		older_d  = older_q;
		newer_d  = newer_q;
		emit     = 1'b0;
		tri_out.first_vertex  = VERTEX_BITS'(v);
		tri_out.second_vertex = VERTEX_BITS'(newer_q);
		tri_out.third_vertex  = VERTEX_BITS'(older_q);
		case (prim_mode)
			MODE_LIST: begin
				if (fill_q == 2'd2) begin
					emit   = 1'b1;
					fill_d = 2'd0;
				end else begin
					fill_d = fill_q + 2'd1;
				end
				older_d = newer_q;
				newer_d = v;
			end
			MODE_STRIP: begin
				if (fill_q == 2'd2) begin
					emit     = distinct;
					parity_d = ~parity_q;
					if (parity_q ^ start_odd) begin
						tri_out.first_vertex = VERTEX_BITS'(older_q);
						tri_out.third_vertex = VERTEX_BITS'(v);
					end
				end else begin
					fill_d = fill_q + 2'd1;
				end
				older_d = newer_q;
				newer_d = v;
			end
			default: ;
		endcase
		if (last) begin
			fill_d   = 2'd0;
			parity_d = 1'b0;
		end
	end

	assign push = en & emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= 2'd0;
			parity_q <= 1'b0;
		end else if (en) begin
			fill_q   <= fill_d;
			parity_q <= parity_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			older_q <= older_d;
			newer_q <= newer_d;
		end
	end

endmodule

FILE: hw/rtl/tpa_obuf.sv
module tpa_obuf import tpa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  tri_t       push_data,
	output logic       in_ready,
	output logic       m_tvalid,
	input  logic       m_tready,
	output tri_t       m_data,
	output obuf_stat_t stat
);

	logic out_vld_q, skid_vld_q;
	tri_t out_q, skid_q;
	logic load;

	assign in_ready = ~skid_vld_q;
	assign load     = ~out_vld_q | m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (load) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= push;
			end
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= skid_vld_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	assign m_tvalid      = out_vld_q;
	assign m_data        = out_q;
	assign stat.out_vld  = out_vld_q;
	assign stat.skid_vld = skid_vld_q;

endmodule

FILE: verif/triangle_primitive_assembler_tb.sv
`timescale 1ns / 100ps

module triangle_primitive_assembler_tb;
	import tpa_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 4;

	typedef struct {
		logic [VERTEX_BITS-1:0] vidx;
		logic                   lst;
	} idx_beat_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      s_tvalid = 1'b0;
	logic                      s_tready;
	logic [TDATA_IN_BITS-1:0]  s_tdata = '0;   // [15:0] vertex_index
	logic                      s_tlast = 1'b0;
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	logic [TDATA_OUT_BITS-1:0] m_tdata;        // [15:0] first, [31:16] second, [47:32] third
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

	triangle_primitive_assembler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// assembler state as the block should hold it
	logic [1:0]             cur_mode = MODE_LIST;
	logic                   cur_start_odd = 1'b0;
	logic [VERTEX_BITS-1:0] held_older = '0;
	logic [VERTEX_BITS-1:0] held_newer = '0;
	logic [1:0]             group_fill = '0;
	logic                   strip_phase = 1'b0;

	idx_beat_t pend_idx[$];
	tri_t      tri_due[$];
	int        beats_left = 0;
	int        errors = 0;
	int        idle_cycles = 0;
	logic      in_fired = 1'b0;
	bit        idle_on = 1'b0;
	int        in_gap = 0;
	int        rx_wait = 0;
	int        hold_left = 0;
	bit        hold_req = 1'b0;
	bit        hold_done = 1'b0;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [VERTEX_BITS-1:0] pick_vertex(bit tight);
		int r;
		if (tight)
			return VERTEX_BITS'($urandom_range(0, 5));
		r = $urandom_range(0, 19);
		if (r == 0)
			return '1;
		else if (r == 1)
			return '0;
		return VERTEX_BITS'($urandom_range(0, 65535));
	endfunction

	task automatic assemble_index(logic [VERTEX_BITS-1:0] v, logic lst);
		tri_t t;
		if (cur_mode == MODE_LIST) begin
			if (group_fill == 2'd2) begin
				t.first_vertex = v;
				t.second_vertex = held_newer;
				t.third_vertex = held_older;
				tri_due = {tri_due, t};
				group_fill = '0;
			end else begin
				group_fill = group_fill + 2'd1;
			end
			held_older = held_newer;
			held_newer = v;
		end else if (cur_mode == MODE_STRIP) begin
			if (group_fill == 2'd2) begin
				if (held_older != held_newer && held_older != v && held_newer != v) begin
					if ((strip_phase ^ cur_start_odd) == 1'b0) begin
						t.first_vertex = v;
						t.third_vertex = held_older;
					end else begin
						t.first_vertex = held_older;
						t.third_vertex = v;
					end
					t.second_vertex = held_newer;
					tri_due = {tri_due, t};
				end
				strip_phase = ~strip_phase;
			end else begin
				group_fill = group_fill + 2'd1;
			end
			held_older = held_newer;
			held_newer = v;
		end
		if (lst) begin
			group_fill = '0;
			strip_phase = 1'b0;
		end
	endtask

	// accepted beats on both sides, triangle check, watchdog
	always @(posedge clk) begin : watch
		tri_t got, want;
		bit   moved;
		moved = 1'b0;
		in_fired <= s_tvalid && s_tready;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				assemble_index(s_tdata[VERTEX_BITS-1:0], s_tlast);
				beats_left--;
				moved = 1'b1;
			end
			if (cfg_valid && cfg_ready)
				moved = 1'b1;
			if (m_tvalid && m_tready) begin
				moved = 1'b1;
				got = m_tdata;
				if (tri_due.size() == 0) begin
					errors++;
					$display("%0t: triangle expected none actual %h/%h/%h", $realtime,
						got.first_vertex, got.second_vertex, got.third_vertex);
				end else begin
					want = tri_due.pop_front();
					if (got.first_vertex !== want.first_vertex) begin
						errors++;
						$display("%0t: first_vertex expected %h actual %h", $realtime,
							want.first_vertex, got.first_vertex);
					end
					if (got.second_vertex !== want.second_vertex) begin
						errors++;
						$display("%0t: second_vertex expected %h actual %h", $realtime,
							want.second_vertex, got.second_vertex);
					end
					if (got.third_vertex !== want.third_vertex) begin
						errors++;
						$display("%0t: third_vertex expected %h actual %h", $realtime,
							want.third_vertex, got.third_vertex);
					end
				end
			end
		end
		idle_cycles = moved ? 0 : idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("triangle_primitive_assembler: mismatch");
			$finish;
		end
	end

	// index driver
	always @(negedge clk) begin : drive
		idx_beat_t b;
		if (!s_tvalid || in_fired) begin
			if (in_gap > 0) begin
				in_gap--;
				s_tvalid <= 1'b0;
			end else if (pend_idx.size() != 0) begin
				b = pend_idx.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= b.vidx;
				s_tlast <= b.lst;
				in_gap = idle_on ? pick_gap() : 0;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// triangle sink
	always @(negedge clk) begin
		if (hold_req && !hold_done) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (rx_wait > 0) begin
			rx_wait--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			rx_wait = idle_on ? pick_gap() : 0;
		end
	end

	task automatic push_idx(logic [VERTEX_BITS-1:0] v, logic lst);
		idx_beat_t b;
		b.vidx = v;
		b.lst = lst;
		pend_idx = {pend_idx, b};
		beats_left++;
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (beats_left != 0 || tri_due.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == REG_PRIM_MODE)
			cur_mode = val;
		else
			cur_start_odd = val[0];
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// well-formed lists/strips with random content, plus some broken runs and noise
	task automatic add_traffic(int count, bit list_shape);
		int  added, len, kind, k;
		bit  tight;
		added = 0;
		while (added < count) begin
			kind = $urandom_range(0, 99);
			tight = ($urandom_range(0, 9) < 3);
			if (kind < 10) begin
				len = $urandom_range(1, 6);
				for (k = 0; k < len; k++)
					push_idx(pick_vertex(tight), $urandom_range(0, 3) == 0);
			end else begin
				if (list_shape)
					len = 3 * $urandom_range(1, 4) + (kind < 25 ? $urandom_range(1, 2) : 0);
				else
					len = (kind < 25) ? $urandom_range(1, 2) : $urandom_range(3, 12);
				for (k = 0; k < len; k++)
					push_idx(pick_vertex(tight), k == len - 1);
			end
			added += len;
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// list mode out of reset: extremes, leftovers, single-index list
		push_idx(16'hFFFF, 1'b0);
		push_idx(16'h0000, 1'b0);
		push_idx(16'h8000, 1'b0);
		push_idx(16'd5, 1'b0);
		push_idx(16'd6, 1'b1);
		push_idx(16'd1, 1'b0);
		push_idx(16'd2, 1'b0);
		push_idx(16'd3, 1'b1);
		push_idx(16'd9, 1'b1);
		wait_idle();

		// strips: winding alternation, repeated index, short strip
		write_reg(REG_PRIM_MODE, MODE_STRIP);
		write_reg(REG_START_ODD, 1'b0);
		push_idx(16'h0000, 1'b0);
		push_idx(16'h0001, 1'b0);
		push_idx(16'hFFFF, 1'b0);
		push_idx(16'h0002, 1'b1);
		push_idx(16'd7, 1'b0);
		push_idx(16'd7, 1'b0);
		push_idx(16'd8, 1'b0);
		push_idx(16'd9, 1'b1);
		push_idx(16'd4, 1'b0);
		push_idx(16'd5, 1'b1);
		wait_idle();

		write_reg(REG_START_ODD, 1'b1);
		push_idx(16'd10, 1'b0);
		push_idx(16'd11, 1'b0);
		push_idx(16'd12, 1'b0);
		push_idx(16'd13, 1'b1);
		wait_idle();

		// no-output mode, then mode changes mid-stream keep counters
		write_reg(REG_PRIM_MODE, MODE_NONE);
		push_idx(16'd20, 1'b0);
		push_idx(16'd21, 1'b1);
		wait_idle();
		write_reg(REG_PRIM_MODE, MODE_LIST);
		push_idx(16'd30, 1'b0);
		push_idx(16'd31, 1'b0);
		wait_idle();
		write_reg(REG_PRIM_MODE, MODE_STRIP);
		push_idx(16'd32, 1'b0);
		push_idx(16'd33, 1'b1);
		wait_idle();

		write_reg(REG_PRIM_MODE, MODE_LIST);
		write_reg(REG_START_ODD, 1'b0);
		idle_on = 1'b1;
		add_traffic(300, 1'b1);
		wait_idle();

		write_reg(REG_PRIM_MODE, MODE_STRIP);
		hold_req = 1'b1;
		add_traffic(350, 1'b0);
		wait_idle();

		write_reg(REG_START_ODD, 1'b1);
		idle_on = 1'b0;
		add_traffic(300, 1'b0);
		wait_idle();

		write_reg(REG_PRIM_MODE, MODE_UNUSED);
		add_traffic(30, 1'b0);
		wait_idle();

		write_reg(REG_PRIM_MODE, MODE_NONE);
		idle_on = 1'b1;
		add_traffic(30, 1'b0);
		wait_idle();

		write_reg(REG_PRIM_MODE, MODE_LIST);
		add_traffic(250, 1'b1);
		wait_idle();

		write_reg(REG_PRIM_MODE, MODE_STRIP);
		add_traffic(300, 1'b0);
		wait_idle();

		repeat (8) @(negedge clk);
		if (errors == 0)
			$display("triangle_primitive_assembler: match");
		else
			$display("triangle_primitive_assembler: mismatch");
		$finish;
	end

endmodule
